/* sv/obr_pkg.sv */
// ----------------------------------------------------------------------------
// OHLCV bar resampler package
// Field widths, item types and sequencer states shared by the resampler.
// ----------------------------------------------------------------------------
package obr_pkg;

    localparam int TIME_BITS    = 40;
    localparam int PRICE_BITS   = 32;
    localparam int IN_VOL_BITS  = 40;
    localparam int VOLUME_BITS  = 48;
    localparam int PERIOD_BITS  = 32;
    localparam int CNT_BITS     = $clog2(TIME_BITS);

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(3600);

    typedef struct packed {
        logic [TIME_BITS-1:0]   bar_time;
        logic [PRICE_BITS-1:0]  bar_open;
        logic [PRICE_BITS-1:0]  bar_high;
        logic [PRICE_BITS-1:0]  bar_low;
        logic [PRICE_BITS-1:0]  bar_close;
        logic [IN_VOL_BITS-1:0] bar_volume;
        logic                   series_end;
    } t_bar_in;

    typedef struct packed {
        logic [TIME_BITS-1:0]   bucket_start;
        logic [PRICE_BITS-1:0]  out_open;
        logic [PRICE_BITS-1:0]  out_high;
        logic [PRICE_BITS-1:0]  out_low;
        logic [PRICE_BITS-1:0]  out_close;
        logic [VOLUME_BITS-1:0] out_volume;
        logic                   run_last;
        logic                   final_bar;
    } t_bar_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CMP,
        ST_EMIT_OLD,
        ST_UPDATE,
        ST_EMIT_END
    } t_state;

endpackage

/* sv/obr_mod_unit.sv */
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Radix-2 restoring remainder of a timestamp by the bucket period, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module obr_mod_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [obr_pkg::TIME_BITS-1:0]       i_dividend,
    input  logic [obr_pkg::PERIOD_BITS-1:0]     i_divisor,
    output logic                                o_done,
    output logic [obr_pkg::PERIOD_BITS-1:0]     o_rem
);

    logic                               r_busy;
    logic                               r_done;
    logic [obr_pkg::CNT_BITS-1:0]       r_cnt;
    logic [obr_pkg::TIME_BITS-1:0]      r_dvd;
    logic [obr_pkg::PERIOD_BITS-1:0]    r_div;
    logic [obr_pkg::PERIOD_BITS-1:0]    r_rem;
    logic [obr_pkg::PERIOD_BITS:0]      w_trial;
    logic [obr_pkg::PERIOD_BITS:0]      w_diff;
    logic [obr_pkg::PERIOD_BITS-1:0]    n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[obr_pkg::TIME_BITS-1]};
        w_diff  = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_diff[obr_pkg::PERIOD_BITS-1:0];
        end else begin
            n_rem = w_trial[obr_pkg::PERIOD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= obr_pkg::CNT_BITS'(obr_pkg::TIME_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= (i_divisor == '0) ? obr_pkg::PERIOD_BITS'(1) : i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[obr_pkg::TIME_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("remainder done without a running pass");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("remainder unit restarted while busy");
`endif

endmodule

/* sv/ohlcv_bar_resampler.sv */
// ----------------------------------------------------------------------------
// OHLCV bar resampler
// Merges time-ordered source bars into coarser bars on a fixed time grid.
// ----------------------------------------------------------------------------
// One input item is handled at a time. An item is taken, its timestamp is
// reduced in the shared remainder unit (bit-serial steps over the 40-bit
// timestamp by the period, then the remainder is handed back), the bar is
// placed in its bucket and merged; each result is loaded into the output
// register once that register is free. Each item gives zero, one or two
// result items; the output register holds a result while the next input
// item is taken.
module ohlcv_bar_resampler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [obr_pkg::PERIOD_BITS-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  obr_pkg::t_bar_in                    i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output obr_pkg::t_bar_out                   o_out
);

    obr_pkg::t_state                    r_state;
    obr_pkg::t_state                    n_state;
    logic [obr_pkg::PERIOD_BITS-1:0]    r_period;
    obr_pkg::t_bar_in                   r_in;
    logic [obr_pkg::TIME_BITS-1:0]      r_bucket;
    logic                               r_hit;
    logic                               r_held;
    logic [obr_pkg::TIME_BITS-1:0]      r_held_start;
    logic [obr_pkg::PRICE_BITS-1:0]     r_held_open;
    logic [obr_pkg::PRICE_BITS-1:0]     r_held_high;
    logic [obr_pkg::PRICE_BITS-1:0]     r_held_low;
    logic [obr_pkg::PRICE_BITS-1:0]     r_held_close;
    logic [obr_pkg::VOLUME_BITS-1:0]    r_held_volume;
    logic                               r_out_valid;
    obr_pkg::t_bar_out                  r_out;

    logic                               w_accept;
    logic                               w_slot;
    logic                               w_load_old;
    logic                               w_load_end;
    logic                               w_update;
    logic                               w_div_done;
    logic [obr_pkg::PERIOD_BITS-1:0]    w_rem;
    logic [obr_pkg::VOLUME_BITS:0]      w_vol_sum;
    logic [obr_pkg::VOLUME_BITS-1:0]    w_vol_sat;

    obr_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (i_in.bar_time),
        .i_divisor  (r_period),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    assign w_slot = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            obr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = obr_pkg::ST_DIV;
                end
            end
            obr_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = obr_pkg::ST_CMP;
                end
            end
            obr_pkg::ST_CMP: begin
                if (r_held && (r_held_start != r_bucket)) begin
                    n_state = obr_pkg::ST_EMIT_OLD;
                end else begin
                    n_state = obr_pkg::ST_UPDATE;
                end
            end
            obr_pkg::ST_EMIT_OLD: begin
                if (w_slot) begin
                    n_state = obr_pkg::ST_UPDATE;
                end
            end
            obr_pkg::ST_UPDATE: begin
                if (r_in.series_end) begin
                    n_state = obr_pkg::ST_EMIT_END;
                end else begin
                    n_state = obr_pkg::ST_IDLE;
                end
            end
            obr_pkg::ST_EMIT_END: begin
                if (w_slot) begin
                    n_state = obr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = obr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_load_old = 1'b0;
        w_load_end = 1'b0;
        w_update   = 1'b0;
        case (r_state)
            obr_pkg::ST_IDLE:     o_in_ready = 1'b1;
            obr_pkg::ST_EMIT_OLD: w_load_old = w_slot;
            obr_pkg::ST_UPDATE:   w_update   = 1'b1;
            obr_pkg::ST_EMIT_END: w_load_end = w_slot;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        w_vol_sum = {1'b0, r_held_volume}
                  + (obr_pkg::VOLUME_BITS + 1)'(r_in.bar_volume);
        if (w_vol_sum[obr_pkg::VOLUME_BITS]) begin
            w_vol_sat = '1;
        end else begin
            w_vol_sat = w_vol_sum[obr_pkg::VOLUME_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= obr_pkg::ST_IDLE;
            r_period    <= obr_pkg::PERIOD_RESET;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_period <= i_cfg_data;
            end
            if (w_update) begin
                r_held <= 1'b1;
            end else if (w_load_end) begin
                r_held <= 1'b0;
            end
            if (w_load_old || w_load_end) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in;
        end
        if (w_div_done) begin
            r_bucket <= r_in.bar_time - obr_pkg::TIME_BITS'(w_rem);
        end
        if (r_state == obr_pkg::ST_CMP) begin
            r_hit <= r_held && (r_held_start == r_bucket);
        end
        if (w_update) begin
            r_held_close <= r_in.bar_close;
            if (r_hit) begin
                if (r_in.bar_high > r_held_high) begin
                    r_held_high <= r_in.bar_high;
                end
                if (r_in.bar_low < r_held_low) begin
                    r_held_low <= r_in.bar_low;
                end
                r_held_volume <= w_vol_sat;
            end else begin
                r_held_start  <= r_bucket;
                r_held_open   <= r_in.bar_open;
                r_held_high   <= r_in.bar_high;
                r_held_low    <= r_in.bar_low;
                r_held_volume <= obr_pkg::VOLUME_BITS'(r_in.bar_volume);
            end
        end
        if (w_load_old || w_load_end) begin
            r_out.bucket_start <= r_held_start;
            r_out.out_open     <= r_held_open;
            r_out.out_high     <= r_held_high;
            r_out.out_low      <= r_held_low;
            r_out.out_close    <= r_held_close;
            r_out.out_volume   <= r_held_volume;
            r_out.run_last     <= w_load_end || !r_in.series_end;
            r_out.final_bar    <= w_load_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_old || w_load_end) |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken item");
    a_emit_old_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == obr_pkg::ST_EMIT_OLD) |-> r_held)
        else $error("older bar emitted with no bar held");
    a_end_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_end |=> !r_held)
        else $error("held bar kept after series end");
`endif

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// OHLCV bar resampler testbench
// Feeds source bars through the valid/ready input channel, predicts the merged
// bars for each accepted item, and checks every result item against them in
// order. The period register is swept across several settings, extremes too.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 120;
    localparam int HEAVY_ITEMS   = 270;

    localparam logic [obr_pkg::PRICE_BITS-1:0]  MAX_PRICE  = '1;
    localparam logic [obr_pkg::TIME_BITS-1:0]   MAX_TIME   = '1;
    localparam logic [obr_pkg::IN_VOL_BITS-1:0] MAX_VOL    = '1;
    localparam logic [obr_pkg::PERIOD_BITS-1:0] MAX_PERIOD = '1;

    class bucket_board;
        logic [obr_pkg::PERIOD_BITS-1:0] period;
        logic                            held;
        logic [obr_pkg::TIME_BITS-1:0]   held_start;
        logic [obr_pkg::PRICE_BITS-1:0]  held_open;
        logic [obr_pkg::PRICE_BITS-1:0]  held_high;
        logic [obr_pkg::PRICE_BITS-1:0]  held_low;
        logic [obr_pkg::PRICE_BITS-1:0]  held_close;
        logic [obr_pkg::VOLUME_BITS-1:0] held_volume;
        obr_pkg::t_bar_out               pending_bars[$];
        int                              fail_count;

        function new();
            period      = obr_pkg::PERIOD_RESET;
            held        = 1'b0;
            held_start  = '0;
            held_open   = '0;
            held_high   = '0;
            held_low    = '0;
            held_close  = '0;
            held_volume = '0;
            fail_count  = 0;
        endfunction

        function void set_period(logic [obr_pkg::PERIOD_BITS-1:0] p);
            period = p;
        endfunction

        function obr_pkg::t_bar_out held_bar(logic flush);
            obr_pkg::t_bar_out r;
            r.bucket_start = held_start;
            r.out_open     = held_open;
            r.out_high     = held_high;
            r.out_low      = held_low;
            r.out_close    = held_close;
            r.out_volume   = held_volume;
            r.run_last     = 1'b0;
            r.final_bar    = flush;
            return r;
        endfunction

        function void take_bar(obr_pkg::t_bar_in b);
            longint unsigned               per, t, bucket;
            logic [obr_pkg::VOLUME_BITS:0] sum;
            int                            n_queued;
            per      = (period == 0) ? 64'd1 : 64'(period);
            t        = 64'(b.bar_time);
            bucket   = t - (t % per);
            n_queued = pending_bars.size();
            if (held && held_start == bucket[obr_pkg::TIME_BITS-1:0]) begin
                if (b.bar_high > held_high) held_high = b.bar_high;
                if (b.bar_low < held_low) held_low = b.bar_low;
                held_close  = b.bar_close;
                sum         = held_volume + b.bar_volume;
                held_volume = sum[obr_pkg::VOLUME_BITS] ? '1
                                                        : sum[obr_pkg::VOLUME_BITS-1:0];
            end else begin
                if (held) pending_bars.insert(pending_bars.size(), held_bar(1'b0));
                held        = 1'b1;
                held_start  = bucket[obr_pkg::TIME_BITS-1:0];
                held_open   = b.bar_open;
                held_high   = b.bar_high;
                held_low    = b.bar_low;
                held_close  = b.bar_close;
                held_volume = obr_pkg::VOLUME_BITS'(b.bar_volume);
            end
            if (b.series_end) begin
                pending_bars.insert(pending_bars.size(), held_bar(1'b1));
                held = 1'b0;
            end
            if (pending_bars.size() > n_queued)
                pending_bars[pending_bars.size()-1].run_last = 1'b1;
        endfunction

        function string bar_text(obr_pkg::t_bar_out r);
            return $sformatf("start %h o %h h %h l %h c %h v %h last %b fin %b",
                             r.bucket_start, r.out_open, r.out_high, r.out_low,
                             r.out_close, r.out_volume, r.run_last, r.final_bar);
        endfunction

        function void match_bar(obr_pkg::t_bar_out got);
            obr_pkg::t_bar_out want;
            if (pending_bars.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected bar: %s", bar_text(got));
                return;
            end
            want = pending_bars.pop_front();
            if (got.bucket_start !== want.bucket_start || got.out_open !== want.out_open ||
                got.out_high !== want.out_high || got.out_low !== want.out_low ||
                got.out_close !== want.out_close || got.out_volume !== want.out_volume ||
                got.run_last !== want.run_last || got.final_bar !== want.final_bar) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("bar mismatch at %0t\n  expected %s\n  actual   %s",
                             $time, bar_text(want), bar_text(got));
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [obr_pkg::PERIOD_BITS-1:0] i_cfg_data = obr_pkg::PERIOD_RESET;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    obr_pkg::t_bar_in                i_in = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    obr_pkg::t_bar_out               o_out;

    bucket_board board;
    int          burst_left = 0;
    int          rx_left = 0;
    int          rx_kind = 0;
    int          cycle_count = 0;

    ohlcv_bar_resampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: segments of steady ready, stall, or coin-flip ready
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_kind = $urandom_range(0, 3);
            rx_left = $urandom_range(1, 64);
        end else begin
            rx_left--;
        end
        case (rx_kind)
            0, 1: i_out_ready <= 1'b1;
            2: i_out_ready <= 1'b0;
            default: i_out_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.match_bar(o_out);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [obr_pkg::TIME_BITS-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[obr_pkg::TIME_BITS-1:0];
    endfunction

    function automatic logic [obr_pkg::PRICE_BITS-1:0] pick_price();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return MAX_PRICE;
            2, 3: return obr_pkg::PRICE_BITS'($urandom_range(1000, 2000));
            default: return obr_pkg::PRICE_BITS'($urandom);
        endcase
    endfunction

    function automatic obr_pkg::t_bar_in make_bar(logic [obr_pkg::TIME_BITS-1:0] t,
                                                  logic last);
        obr_pkg::t_bar_in b;
        logic [63:0]      r;
        r            = {$urandom, $urandom};
        b.bar_time   = t;
        b.bar_open   = pick_price();
        b.bar_high   = pick_price();
        b.bar_low    = pick_price();
        b.bar_close  = pick_price();
        case ($urandom_range(0, 9))
            0: b.bar_volume = '0;
            1: b.bar_volume = MAX_VOL;
            2, 3, 4: b.bar_volume = obr_pkg::IN_VOL_BITS'($urandom_range(0, 100000));
            default: b.bar_volume = r[obr_pkg::IN_VOL_BITS-1:0];
        endcase
        b.series_end = last;
        return b;
    endfunction

    task automatic send_bar(input obr_pkg::t_bar_in b);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 60)
                                               : $urandom_range(0, 8);
        end
        burst_left--;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.take_bar(b);
    endtask

    task automatic send_fixed(input logic [obr_pkg::TIME_BITS-1:0] t,
                              input logic [obr_pkg::PRICE_BITS-1:0] o, h, l, c,
                              input logic [obr_pkg::IN_VOL_BITS-1:0] v,
                              input logic last);
        obr_pkg::t_bar_in b;
        b.bar_time   = t;
        b.bar_open   = o;
        b.bar_high   = h;
        b.bar_low    = l;
        b.bar_close  = c;
        b.bar_volume = v;
        b.series_end = last;
        send_bar(b);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending_bars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [obr_pkg::PERIOD_BITS-1:0] p);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= p;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_period(p);
    endtask

    task automatic run_directed();
        send_fixed(0, 0, 0, 0, 0, 0, 1'b0);
        send_fixed(100, 5, MAX_PRICE, 0, 7, MAX_VOL, 1'b0);
        send_fixed(3599, MAX_PRICE, 1, MAX_PRICE, MAX_PRICE, MAX_VOL, 1'b0);
        send_fixed(3600, 10, 20, 5, 15, 1, 1'b0);
        send_fixed(3700, 11, 25, 4, 12, 2, 1'b1);
        send_fixed(7200, 1, 1, 1, 1, 3, 1'b1);
        send_fixed(10000, 30, 40, 20, 35, 9, 1'b0);
        send_fixed(20000, 31, 41, 21, 36, 8, 1'b1);
        send_fixed(5000, 50, 60, 40, 55, 7, 1'b0);
        send_fixed(100, 51, 61, 41, 56, 6, 1'b0);
        send_fixed(100, 52, 62, 42, 57, 5, 1'b1);
        send_fixed(MAX_TIME, MAX_PRICE, MAX_PRICE, MAX_PRICE, MAX_PRICE, MAX_VOL, 1'b0);
        send_fixed(MAX_TIME, 0, 0, 0, 0, MAX_VOL, 1'b1);
        drain();
        write_period(0);
        send_fixed(5, 1, 2, 0, 1, 4, 1'b0);
        send_fixed(5, 2, 3, 1, 2, 4, 1'b0);
        send_fixed(6, 3, 4, 2, 3, 4, 1'b0);
        send_fixed(6, 4, 5, 3, 4, 4, 1'b1);
        drain();
        write_period(MAX_PERIOD);
        send_fixed(40'hFF_FFFF_FFFE, 7, 8, 6, 7, 1, 1'b0);
        send_fixed(40'hFF_FFFF_FFFF, 8, 9, 7, 8, 1, 1'b0);
        send_fixed(MAX_TIME, 9, 10, 8, 9, 1, 1'b1);
        drain();
        write_period(1);
        send_fixed(0, 1, 1, 1, 1, 1, 1'b0);
        send_fixed(1, 2, 2, 2, 2, 2, 1'b1);
    endtask

    task automatic heavy_bucket(input int n_items);
        longint unsigned  base;
        obr_pkg::t_bar_in b;
        base = longint'($urandom_range(0, 255)) * 64'(MAX_PERIOD);
        for (int i = 0; i < n_items; i++) begin
            b = make_bar(obr_pkg::TIME_BITS'(base + $urandom_range(0, 100000)),
                         i == n_items - 1);
            b.bar_volume = MAX_VOL - obr_pkg::IN_VOL_BITS'($urandom_range(0, 15));
            send_bar(b);
        end
    endtask

    task automatic run_series(input logic [obr_pkg::PERIOD_BITS-1:0] p,
                              input int n_items);
        longint unsigned span, t;
        int              sent, len;
        logic            last;
        span = (p == 0) ? 64'd1 : 64'(p);
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 16);
            t = ($urandom_range(0, 3) == 0) ? 64'(rand_time()) : 64'($urandom);
            for (int i = 0; i < len && sent < n_items; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_bar(make_bar(rand_time(), 1'($urandom_range(0, 1))));
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: t += $urandom_range(0, 32'(span / 4));
                        6, 7: t += span * $urandom_range(1, 3);
                        8: t -= $urandom_range(1, 32'(span));
                        default: ;
                    endcase
                    last = (i == len - 1) || ($urandom_range(0, 29) == 0);
                    send_bar(make_bar(t[obr_pkg::TIME_BITS-1:0], last));
                end
                sent++;
            end
        end
    endtask

    initial begin
        logic [obr_pkg::PERIOD_BITS-1:0] phase_period [9];
        phase_period[0] = obr_pkg::PERIOD_RESET;
        phase_period[1] = 1;
        phase_period[2] = 0;
        phase_period[3] = MAX_PERIOD;
        phase_period[4] = 60;
        phase_period[5] = 86400;
        phase_period[6] = $urandom;
        phase_period[7] = $urandom_range(2, 16);
        phase_period[8] = 300;

        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        foreach (phase_period[k]) begin
            drain();
            write_period(phase_period[k]);
            if (phase_period[k] == MAX_PERIOD)
                heavy_bucket(HEAVY_ITEMS);
            run_series(phase_period[k], PHASE_ITEMS);
        end
        drain();

        if (board.pending_bars.size() != 0) begin
            $display("%0d bars never arrived", board.pending_bars.size());
            board.fail_count += board.pending_bars.size();
        end
        if (board.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
sv/obr_pkg.sv
sv/obr_mod_unit.sv
sv/ohlcv_bar_resampler.sv
verif/testbench.sv
